/* rtl/sitda_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants for the integer to ASCII converter
// Character codes, digit sizing and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int CHAR_BITS  = 6;
	localparam int DIGIT_BITS = 4;

	localparam logic [CHAR_BITS-1:0] CODE_MINUS = 6'd45;
	localparam logic [CHAR_BITS-1:0] CODE_ZERO  = 6'd48;

	// decimal digits needed for the largest unsigned value of the given width
	function automatic int dec_digits(input int bits);
		return (bits * 30103) / 100000 + 1;
	endfunction

	typedef struct packed {
		logic load;
		logic shift;
		logic put_sign;
		logic put_digit;
		logic drop_digit;
	} cmd_t;

	typedef struct packed {
		logic neg;
		logic conv_done;
		logic lead_zero;
		logic final_digit;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

/* rtl/sitda_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_in_if: input channel of the integer to ASCII converter
// Carries one signed integer per beat under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sitda_in_if #(
	parameter int VALUE_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

/* rtl/sitda_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_out_if: output channel of the integer to ASCII converter
// Carries one ASCII character per beat and a flag on the final one.
// ----------------------------------------------------------------------------
interface sitda_out_if;
	logic                             valid;
	logic                             ready;
	logic [sitda_pkg::CHAR_BITS-1:0]  char_code;
	logic                             last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

/* rtl/sitda_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_ctrl: sequencing state machine
// Steps the datapath through load, binary to BCD shifting, sign and digits.
// ----------------------------------------------------------------------------
module sitda_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire sitda_pkg::sts_t sts,
	output sitda_pkg::cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SIGN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
				if (sts.conv_done) begin
					state_d = sts.neg ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					cmd.put_sign = 1'b1;
					state_d      = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.lead_zero && !sts.final_digit) begin
					cmd.drop_digit = 1'b1;
				end else if (sts.out_free) begin
					cmd.put_digit = 1'b1;
					if (sts.final_digit) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/sitda_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_dp: conversion datapath
// Magnitude register, shift-and-add-3 BCD register, shared shift and digit
// counter, and the output character register.
// ----------------------------------------------------------------------------
module sitda_dp #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic signed [VALUE_BITS-1:0]    value,
	input  wire sitda_pkg::cmd_t                 cmd,
	output sitda_pkg::sts_t                      sts,
	input  wire logic                            out_ready,
	output logic                                 out_valid,
	output logic [sitda_pkg::CHAR_BITS-1:0]      char_code,
	output logic                                 last
);

	localparam int DB       = sitda_pkg::DIGIT_BITS;
	localparam int ND       = sitda_pkg::dec_digits(VALUE_BITS);
	localparam int BCD_BITS = ND * DB;
	localparam int CW       = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0]           value_u;
	logic [VALUE_BITS-1:0]           mag_q;
	logic [BCD_BITS-1:0]             bcd_q;
	logic [BCD_BITS-1:0]             bcd_adj;
	logic                            neg_q;
	logic [CW-1:0]                   cnt_q;
	logic                            started_q;
	logic                            out_valid_q;
	logic [sitda_pkg::CHAR_BITS-1:0] char_q;
	logic                            last_q;
	logic [DB-1:0]                   top_digit;
	logic                            out_free;

	assign value_u   = value;
	assign top_digit = bcd_q[BCD_BITS-1 -: DB];
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[i*DB +: DB] >= DB'(5)) begin
				bcd_adj[i*DB +: DB] = bcd_q[i*DB +: DB] + DB'(3);
			end else begin
				bcd_adj[i*DB +: DB] = bcd_q[i*DB +: DB];
			end
		end
	end

	always_comb begin
		sts.neg         = neg_q;
		sts.conv_done   = (cnt_q == CW'(VALUE_BITS - 1));
		sts.lead_zero   = !started_q && (top_digit == '0);
		sts.final_digit = (cnt_q == CW'(ND - 1));
		sts.out_free    = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
			bcd_q <= '0;
			neg_q <= value_u[VALUE_BITS-1];
			cnt_q <= '0;
		end else if (cmd.shift) begin
			bcd_q <= {bcd_adj[BCD_BITS-2:0], mag_q[VALUE_BITS-1]};
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			cnt_q <= sts.conv_done ? '0 : cnt_q + CW'(1);
		end else if (cmd.put_digit || cmd.drop_digit) begin
			bcd_q <= {bcd_q[BCD_BITS-DB-1:0], DB'(0)};
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.put_sign || cmd.put_digit) begin
			char_q <= cmd.put_sign ? sitda_pkg::CODE_MINUS
				: sitda_pkg::CODE_ZERO + sitda_pkg::CHAR_BITS'(top_digit);
			last_q <= cmd.put_digit && sts.final_digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				started_q <= 1'b0;
			end else if (cmd.put_digit) begin
				started_q <= 1'b1;
			end
			if (cmd.put_sign || cmd.put_digit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

endmodule
`default_nettype wire

/* rtl/signed_int_to_decimal_ascii.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one two's complement integer into its decimal characters, most
// significant first, minus sign for negative values, no leading zeros.
//
//   channel  dir  payload               beats per item
//   din      in   value[VALUE_BITS-1:0]  1
//   dout     out  char_code[5:0], last   1 to 11 (VALUE_BITS = 32)
//
// An item is loaded, shifted through the BCD register in VALUE_BITS
// shift-and-add-3 steps, given a minus sign if negative, then walked one
// digit position of the BCD register at a time (10 positions at 32 bits).
// Reset clears the sequencer and the output valid flag.
// A stall on dout holds sign and digit output, not leading-zero drops; din
// is taken again once the final character sits in the output register.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sitda_in_if.sink   din,
	sitda_out_if.source dout
);

	sitda_pkg::cmd_t cmd;
	sitda_pkg::sts_t sts;

	sitda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sitda_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (din.value),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (dout.ready),
		.out_valid (dout.valid),
		.char_code (dout.char_code),
		.last      (dout.last)
	);

endmodule
`default_nettype wire

/* rtl/sitda_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_chk: port checker for the integer to ASCII converter
// Watches both channels and flags beats that break the text framing.
// ----------------------------------------------------------------------------
module sitda_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [sitda_pkg::CHAR_BITS-1:0] char_code,
	input wire logic                            last
);

	logic [1:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_beat) - 2'(out_beat && last);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last))
		else $error("output beat changed while stalled");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> char_code == sitda_pkg::CODE_MINUS
			|| (char_code >= sitda_pkg::CODE_ZERO
			&& char_code <= sitda_pkg::CODE_ZERO + 6'd9))
		else $error("character code out of range");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_code == sitda_pkg::CODE_MINUS |-> !last)
		else $error("minus sign ends a number");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("input taken again right after a beat");

	a_no_stray_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> pending_q != 2'd0)
		else $error("output beat without a pending number");

endmodule

bind signed_int_to_decimal_ascii sitda_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.char_code (dout.char_code),
	.last      (dout.last)
);
`default_nettype wire
